[rtl/double_ended_queue_defines.svh]
// Assertion macros for the top-level file, which carries the checks.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[rtl/deq_pkg.sv]
package deq_pkg;

    // Fixed widths of the item fields.
    localparam int REQ_W  = 2;
    localparam int DATA_W = 64;
    localparam int STAT_W = 2;
    localparam int FILL_W = 9;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } cmd_t;

endpackage

[rtl/deq_if.sv]
interface deq_req_if;
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [DATA_W-1:0]   item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   popped_value;
    status_t             status;
    logic [FILL_W-1:0]   fill_count;
    logic                is_empty;

    modport source (output valid, output popped_value, output status,
                    output fill_count, output is_empty, input ready);
    modport sink   (input valid, input popped_value, input status,
                    input fill_count, input is_empty, output ready);
endinterface

[rtl/deq_ctrl.sv]
module deq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output deq_pkg::cmd_t cmd
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // A new item may enter when no result is held or the held one leaves now.
    assign in_ready  = (state_reg == ST_IDLE) || out_ready;
    assign out_valid = (state_reg == ST_HOLD);
    assign cmd.exec  = in_valid && in_ready;

    // Next-state logic.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                state_next = cmd.exec ? ST_HOLD : ST_IDLE;
            end
            ST_HOLD:
            begin
                if (cmd.exec)
                begin
                    state_next = ST_HOLD;
                end
                else if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/deq_dp.sv]
module deq_dp #(
    parameter int DEPTH      = 256,
    parameter int WORD_WIDTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  deq_pkg::cmd_t                 cmd,
    input  logic [deq_pkg::REQ_W-1:0]     req_type,
    input  logic [deq_pkg::DATA_W-1:0]    item_value,
    output logic [deq_pkg::DATA_W-1:0]    popped_value,
    output deq_pkg::status_t              status,
    output logic [deq_pkg::FILL_W-1:0]    fill_count,
    output logic                          is_empty
);
    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;

    // Ring storage and its registered read port.
    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    status_t          status_reg;
    status_t          status_next;
    logic             pop_ok_reg;
    logic             pop_ok_next;

    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] head_dec;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] last_sum;
    logic [IDX_W-1:0] tail_idx;
    logic [IDX_W-1:0] last_idx;
    logic             full;
    logic             empty;
    req_t             req;

    assign req   = req_t'(req_type);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Pointer arithmetic, each wrap being a single compare and select.
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum = tail_sum - 1'b1;
    assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
    assign last_idx = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(last_sum);

    // Request decode and state update.
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        addr        = head_reg;
        if (cmd.exec)
        begin
            status_next = STAT_OK;
            pop_ok_next = 1'b0;
            case (req)
                REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        head_next  = head_dec;
                        addr       = head_dec;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        addr       = tail_idx;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        addr        = head_reg;
                        rd_en       = 1'b1;
                        pop_ok_next = 1'b1;
                        head_next   = head_inc;
                        count_next  = count_reg - 1'b1;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        addr        = last_idx;
                        rd_en       = 1'b1;
                        pop_ok_next = 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
    end

    // Single-port memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= item_value[WORD_WIDTH-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // Result fields.
    assign popped_value = pop_ok_reg ? DATA_W'(rd_data_reg) : '0;
    assign status       = status_reg;
    assign fill_count   = FILL_W'(count_reg);
    assign is_empty     = empty;

endmodule

[rtl/double_ended_queue.sv]
// Channel   Dir  Payload                                       Handshake
// req       in   req_type, item_value                          valid / ready
// rsp       out  popped_value, status, fill_count, is_empty    valid / ready
//
// An item is executed in the cycle it is accepted and its result is shown
// in the following cycle from the result registers.
// Memory and pointers update on acceptance, giving one item per cycle unless held.
// A result not taken holds req.ready low until rsp.ready returns.
// Reset clears the head pointer and count; stored words are not cleared.
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
    parameter int DEPTH      = 256,
    parameter int WORD_WIDTH = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);
    import deq_pkg::*;

    cmd_t cmd;

    // Handshake controller.
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Ring buffer datapath.
    deq_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req.req_type),
        .item_value   (req.item_value),
        .popped_value (rsp.popped_value),
        .status       (rsp.status),
        .fill_count   (rsp.fill_count),
        .is_empty     (rsp.is_empty)
    );

    // A refused pop always reports an empty deque.
    `DEQ_ASSERT_NOW(a_refused_pop_empty, rsp.valid && (rsp.status == STAT_EMPTY), rsp.is_empty)
    // A nonzero popped word only comes with a successful request.
    `DEQ_ASSERT_NOW(a_pop_data_ok, rsp.valid && (rsp.popped_value != '0), rsp.status == STAT_OK)
    // A held result blocks the input side.
    `DEQ_ASSERT_NOW(a_hold_blocks_input, rsp.valid && !rsp.ready, !req.ready)
    // Every accepted item produces a result in the next cycle.
    `DEQ_ASSERT_NEXT(a_result_follows, req.valid && req.ready, rsp.valid)

endmodule
